[rtl/core/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_READ,
    S_LOAD
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
    logic load;
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dq_stat_t;

endpackage

[rtl/core/dq_ram.sv]
// Generic RAM with one write port and two registered read ports.
module dq_ram #(
  parameter int WIDTH = dq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/core/dq_ctrl.sv]
// Controller state machine that sequences one queue operation at a time.
module dq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_cmd_t  cmd
);

  dq_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      dq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = dq_pkg::S_UPDATE;
        end
      end
      dq_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = dq_pkg::S_READ;
      end
      dq_pkg::S_READ: begin
        state_nxt = dq_pkg::S_LOAD;
      end
      dq_pkg::S_LOAD: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/dq_datapath.sv]
// Datapath: pointers, entry count, entry store and the result register.
module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dq_pkg::dq_cmd_t       cmd,
  output dq_pkg::dq_stat_t      stat,
  input  logic [1:0]            in_op,
  input  logic [DATA_WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [DATA_WIDTH-1:0] out_front_data,
  output logic [DATA_WIDTH-1:0] out_back_data,
  output logic [CW-1:0]         out_count
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dq_pkg::op_t           op_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [AW-1:0]         front_r, front_nxt;
  logic [AW-1:0]         back_r, back_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  dq_pkg::status_t       status_r, status_nxt;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [DATA_WIDTH-1:0] out_front_r, out_back_r;
  logic [CW-1:0]         out_count_r;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] rdata_front, rdata_back;
  logic [AW-1:0]         front_inc, front_dec, back_inc, back_dec;
  logic                  is_push, is_full, is_empty;

  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign back_inc  = (back_r == LAST_IDX) ? '0 : back_r + AW'(1);
  assign back_dec  = (back_r == '0) ? LAST_IDX : back_r - AW'(1);

  assign is_push  = (op_r == dq_pkg::OP_PUSH_FRONT) || (op_r == dq_pkg::OP_PUSH_BACK);
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = front_r;
    if (cmd.update) begin
      status_nxt = dq_pkg::ST_OK;
      if (is_push) begin
        if (is_full) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
          if (is_empty) begin
            back_nxt = front_r;
            waddr    = front_r;
          end else if (op_r == dq_pkg::OP_PUSH_FRONT) begin
            front_nxt = front_dec;
            waddr     = front_dec;
          end else begin
            back_nxt = back_inc;
            waddr    = back_inc;
          end
        end
      end else begin
        if (is_empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
          if (count_r != CW'(1)) begin
            if (op_r == dq_pkg::OP_POP_FRONT) begin
              front_nxt = front_inc;
            end else begin
              back_nxt = back_dec;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (cmd.capture) begin
      op_r   <= dq_pkg::op_t'(in_op);
      data_r <= in_data;
    end
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (data_r),
    .raddr_a (front_r),
    .raddr_b (back_r),
    .rdata_a (rdata_front),
    .rdata_b (rdata_back)
  );

  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= status_r;
      out_count_r  <= count_r;
      out_front_r  <= is_empty ? '0 : rdata_front;
      out_back_r   <= is_empty ? '0 : rdata_back;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_front_data = out_front_r;
  assign out_back_data  = out_back_r;
  assign out_count      = out_count_r;

endmodule

[rtl/core/double_ended_queue.sv]
// Top level of the bounded double-ended queue.
//
//   Channel | Direction | Handshake            | Word contents
//   --------+-----------+----------------------+---------------------------------------
//   in_     | input     | in_valid / in_stall   | op, data
//   out_    | output    | out_valid / out_stall | status, front_data, back_data, count
//
// Each accepted word passes through capture, pointer and store update, store read
// at the new front and back indices (the store has a registered read), and load into
// the result register. Reset is synchronous and active low; it empties the queue and
// clears the pointers and the result valid, but leaves the store contents alone.
// A stalled result holds in the output register; the next word is still taken, and
// its result waits in the load cycle until the register frees up.
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel: one operation word.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_op,
  input  logic [DATA_WIDTH-1:0] in_data,
  // Result channel: one result word per operation.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [DATA_WIDTH-1:0] out_front_data,
  output logic [DATA_WIDTH-1:0] out_back_data,
  output logic [CW-1:0]         out_count
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  // The controller steps each operation through its phases; it stalls the
  // input whenever it is not idle.
  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath keeps the circular store, the front and back pointers,
  // the entry count and the result register.
  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (in_op),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_front_data (out_front_data),
    .out_back_data  (out_back_data),
    .out_count      (out_count)
  );

endmodule
